/* src/sic_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the segment intersection classifier.
package sic_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } orient_t;

  typedef enum logic [1:0] {
    REL_NONE  = 2'd0,
    REL_TOUCH = 2'd1,
    REL_CROSS = 2'd2
  } relation_t;

endpackage

/* src/sic_orient.sv */
`timescale 1ns / 1ps
// Orientation sign of point c against directed segment a -> b.
module sic_orient (
  input  sic_pkg::point_t  a,
  input  sic_pkg::point_t  b,
  input  sic_pkg::point_t  c,
  output sic_pkg::orient_t orient
);

  localparam int CB = sic_pkg::COORD_BITS;
  localparam int DB = sic_pkg::DIFF_BITS;
  localparam int PB = sic_pkg::PROD_BITS;
  localparam int XB = sic_pkg::CROSS_BITS;

  logic signed [DB-1:0] d_bx;
  logic signed [DB-1:0] d_by;
  logic signed [DB-1:0] d_cx;
  logic signed [DB-1:0] d_cy;
  logic signed [PB-1:0] prod_l;
  logic signed [PB-1:0] prod_r;
  logic signed [XB-1:0] cross_val;

  assign d_bx = $signed({b.x[CB-1], b.x}) - $signed({a.x[CB-1], a.x});
  assign d_by = $signed({b.y[CB-1], b.y}) - $signed({a.y[CB-1], a.y});
  assign d_cx = $signed({c.x[CB-1], c.x}) - $signed({a.x[CB-1], a.x});
  assign d_cy = $signed({c.y[CB-1], c.y}) - $signed({a.y[CB-1], a.y});

  assign prod_l = d_bx * d_cy;
  assign prod_r = d_by * d_cx;
  assign cross_val = $signed({prod_l[PB-1], prod_l}) - $signed({prod_r[PB-1], prod_r});

  assign orient.neg = cross_val[XB-1];
  assign orient.pos = !cross_val[XB-1] && (cross_val != '0);

endmodule

/* src/sic_classify.sv */
`timescale 1ns / 1ps
// Crossing and contact classification of two segments from four orientations.
module sic_classify (
  input  sic_pkg::point_t    p0,
  input  sic_pkg::point_t    p1,
  input  sic_pkg::point_t    q0,
  input  sic_pkg::point_t    q1,
  output sic_pkg::relation_t relation
);

  sic_pkg::orient_t o_pq0;
  sic_pkg::orient_t o_pq1;
  sic_pkg::orient_t o_qp0;
  sic_pkg::orient_t o_qp1;
  logic             crossing;
  logic             touching;

  function automatic logic between(input sic_pkg::coord_t a, input sic_pkg::coord_t b,
                                   input sic_pkg::coord_t c);
    between = (($signed(a) <= $signed(c)) && ($signed(c) <= $signed(b))) ||
              (($signed(b) <= $signed(c)) && ($signed(c) <= $signed(a)));
  endfunction

  function automatic logic touches(input sic_pkg::point_t a, input sic_pkg::point_t b,
                                   input sic_pkg::point_t c, input sic_pkg::orient_t o);
    touches = (c == a) || (c == b) ||
              (!o.pos && !o.neg && between(a.x, b.x, c.x) && between(a.y, b.y, c.y));
  endfunction

  function automatic logic opposite(input sic_pkg::orient_t u, input sic_pkg::orient_t v);
    opposite = (u.pos && v.neg) || (u.neg && v.pos);
  endfunction

  sic_orient u_o_pq0 (.a(p0), .b(p1), .c(q0), .orient(o_pq0));
  sic_orient u_o_pq1 (.a(p0), .b(p1), .c(q1), .orient(o_pq1));
  sic_orient u_o_qp0 (.a(q0), .b(q1), .c(p0), .orient(o_qp0));
  sic_orient u_o_qp1 (.a(q0), .b(q1), .c(p1), .orient(o_qp1));

  assign crossing = opposite(o_pq0, o_pq1) && opposite(o_qp0, o_qp1);
  assign touching = touches(p0, p1, q0, o_pq0) || touches(p0, p1, q1, o_pq1) ||
                    touches(q0, q1, p0, o_qp0) || touches(q0, q1, p1, o_qp1);

  always_comb begin
    if (crossing) begin
      relation = sic_pkg::REL_CROSS;
    end else if (touching) begin
      relation = sic_pkg::REL_TOUCH;
    end else begin
      relation = sic_pkg::REL_NONE;
    end
  end

endmodule

/* src/segment_intersection_classify_unit.sv */
`timescale 1ns / 1ps
// Segment intersection classifier top level: input register, classify logic, result register.
// An accepted input transaction reaches out_valid through the input register and then the result register.
// Throughput: one transaction per cycle without out_stall; the single classify stage sets it.
// The result register frees the input register while a result waits on out_stall.
// Reset clears both valid flags; payload registers are not reset.
module segment_intersection_classify_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sic_pkg::COORD_BITS-1:0]   p_start_x,
  input  logic [sic_pkg::COORD_BITS-1:0]   p_start_y,
  input  logic [sic_pkg::COORD_BITS-1:0]   p_end_x,
  input  logic [sic_pkg::COORD_BITS-1:0]   p_end_y,
  input  logic [sic_pkg::COORD_BITS-1:0]   q_start_x,
  input  logic [sic_pkg::COORD_BITS-1:0]   q_start_y,
  input  logic [sic_pkg::COORD_BITS-1:0]   q_end_x,
  input  logic [sic_pkg::COORD_BITS-1:0]   q_end_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       relation
);

  logic               s1_valid;
  sic_pkg::point_t    s1_p0;
  sic_pkg::point_t    s1_p1;
  sic_pkg::point_t    s1_q0;
  sic_pkg::point_t    s1_q1;
  sic_pkg::relation_t rel_next;
  sic_pkg::relation_t rel;
  logic               out_open;
  logic               s1_open;

  assign out_open = !out_valid || !out_stall;
  assign s1_open  = !s1_valid || out_open;
  assign in_stall = !s1_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_open && in_valid) begin
      s1_p0 <= '{x: p_start_x, y: p_start_y};
      s1_p1 <= '{x: p_end_x,   y: p_end_y};
      s1_q0 <= '{x: q_start_x, y: q_start_y};
      s1_q1 <= '{x: q_end_x,   y: q_end_y};
    end
  end

  sic_classify u_classify (
    .p0       (s1_p0),
    .p1       (s1_p1),
    .q0       (s1_q0),
    .q1       (s1_q1),
    .relation (rel_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid) begin
      rel <= rel_next;
    end
  end

  assign relation = rel;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost at input register");

  a_s1_moves_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("transaction did not advance to result register");

endmodule
